@@ hdl/csh_pkg.sv @@
// Shared types, constants and helpers for the convex support hill climber.
package csh_pkg;

	localparam int unsigned VertexCountDef = 256;
	localparam int unsigned AdjDepthDef    = 1024;

	localparam int unsigned CoordW = 18;
	localparam int unsigned ProdW  = 2 * CoordW;
	localparam int unsigned ValueW = 37;
	localparam int unsigned PosW   = 3 * CoordW;
	localparam int unsigned CountW = 8;
	localparam int unsigned OffW   = 10;
	localparam int unsigned ValW   = CountW + OffW;
	localparam int unsigned NbW    = 8;
	localparam int unsigned SlotW  = 10;
	localparam int unsigned EpochW = 8;

	typedef enum logic [1:0] {
		CMD_WR_VERTEX  = 2'd0,
		CMD_WR_VALENCY = 2'd1,
		CMD_WR_ADJ     = 2'd2,
		CMD_QUERY      = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_START_RD,
		ST_START_W1,
		ST_START_W2,
		ST_START_SET,
		ST_VAL,
		ST_ADJ_RD,
		ST_ADJ,
		ST_VIS,
		ST_NB_W1,
		ST_NB_W2,
		ST_NB_CMP,
		ST_DONE
	} state_t;

	// v mod m by restoring subtraction; exact while v < 256*m
	function automatic logic [16:0] reduce_mod(input logic [16:0] v, input logic [16:0] m);
		logic [24:0] r;
		logic [24:0] d;
		r = {8'b0, v};
		for (int k = 7; k >= 0; k--) begin
			d = {8'b0, m} << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[16:0];
	endfunction

endpackage

@@ hdl/csh_vtx_mem.sv @@
// Vertex position and valency memory, one shared synchronous read port.
module csh_vtx_mem
	import csh_pkg::*;
#(
	parameter int unsigned VERTEX_COUNT = VertexCountDef
) (
	input  logic                             clk,
	input  logic                             pos_we,
	input  logic                             val_we,
	input  logic [$clog2(VERTEX_COUNT)-1:0]  wr_addr,
	input  logic [PosW-1:0]                  pos_wdata,
	input  logic [ValW-1:0]                  val_wdata,
	input  logic                             rd_en,
	input  logic [$clog2(VERTEX_COUNT)-1:0]  rd_addr,
	output logic [PosW-1:0]                  pos_rdata,
	output logic [ValW-1:0]                  val_rdata
);

	logic [PosW-1:0] pos_mem [VERTEX_COUNT];
	logic [ValW-1:0] val_mem [VERTEX_COUNT];

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[wr_addr] <= pos_wdata;
		end
		if (val_we) begin
			val_mem[wr_addr] <= val_wdata;
		end
		if (rd_en) begin
			pos_rdata <= pos_mem[rd_addr];
			val_rdata <= val_mem[rd_addr];
		end
	end

endmodule

@@ hdl/csh_adj_mem.sv @@
// Adjacency list memory, one write and one registered read port.
module csh_adj_mem
	import csh_pkg::*;
#(
	parameter int unsigned ADJ_DEPTH = AdjDepthDef
) (
	input  logic                          clk,
	input  logic                          we,
	input  logic [$clog2(ADJ_DEPTH)-1:0]  wr_addr,
	input  logic [NbW-1:0]                wdata,
	input  logic                          rd_en,
	input  logic [$clog2(ADJ_DEPTH)-1:0]  rd_addr,
	output logic [NbW-1:0]                rdata
);

	logic [NbW-1:0] mem [ADJ_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wdata;
		end
		if (rd_en) begin
			rdata <= mem[rd_addr];
		end
	end

endmodule

@@ hdl/csh_dot.sv @@
// Two-stage dot product: three products, then their sum.
module csh_dot
	import csh_pkg::*;
(
	input  logic                      clk,
	input  logic signed [CoordW-1:0]  dir_x,
	input  logic signed [CoordW-1:0]  dir_y,
	input  logic signed [CoordW-1:0]  dir_z,
	input  logic [PosW-1:0]           pos,
	output logic signed [ValueW-1:0]  dot
);

	logic signed [CoordW-1:0] px, py, pz;
	logic signed [ProdW-1:0]  prod_x_s1, prod_y_s1, prod_z_s1;
	logic signed [ValueW:0]   sum_c;
	logic signed [ValueW-1:0] dot_s2;

	assign px = pos[3*CoordW-1:2*CoordW];
	assign py = pos[2*CoordW-1:CoordW];
	assign pz = pos[CoordW-1:0];

	// sum fits the result width by range
	assign sum_c = (ValueW+1)'(prod_x_s1) + (ValueW+1)'(prod_y_s1) + (ValueW+1)'(prod_z_s1);

	always_ff @(posedge clk) begin
		prod_x_s1 <= ProdW'(px) * ProdW'(dir_x);
		prod_y_s1 <= ProdW'(py) * ProdW'(dir_y);
		prod_z_s1 <= ProdW'(pz) * ProdW'(dir_z);
		dot_s2    <= sum_c[ValueW-1:0];
	end

	assign dot = dot_s2;

endmodule

@@ hdl/convex_support_hill_climb.sv @@
// Top level: command decode, climb sequencer and result register.
// Table writes (vertex, valency, adjacency) each complete in the cycle they
// are accepted. In a query each pass scans the neighbours of the current
// vertex; each adjacency entry costs an adjacency read and a visited-map
// lookup, and every dot product (for the start vertex and for each neighbour
// not yet visited in the query) goes through the single read port of the
// vertex memory and the two-stage multiply/sum pipeline. The visited map is a
// small memory of epoch tags: a vertex counts as visited when its tag equals
// the tag of the running query, and each query takes a fresh tag, so nothing
// is cleared per query. After reset, and again after every 255th query, a
// clearing pass over all VERTEX_COUNT entries zeroes the tags with in_stall
// high. Only one query climbs at a time; in_stall is high for the whole
// climb, and a finished result is held in an output register until taken
// while further table writes and queries are accepted. Vertex and neighbour
// numbers are taken modulo VERTEX_COUNT; adjacency addresses wrap modulo
// ADJ_DEPTH. Vertex and valency writes with a slot at or beyond VERTEX_COUNT
// are dropped.
module convex_support_hill_climb
	import csh_pkg::*;
#(
	parameter int unsigned VERTEX_COUNT = VertexCountDef,
	parameter int unsigned ADJ_DEPTH    = AdjDepthDef
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                command,
	input  logic [SlotW-1:0]          table_slot,
	input  logic [7:0]                start_vertex,
	input  logic signed [CoordW-1:0]  coord_x,
	input  logic signed [CoordW-1:0]  coord_y,
	input  logic signed [CoordW-1:0]  coord_z,
	input  logic [CountW-1:0]         neighbor_count,
	input  logic [OffW-1:0]           neighbor_offset,
	input  logic [NbW-1:0]            neighbor_vertex,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [7:0]                support_vertex,
	output logic signed [ValueW-1:0]  support_value
);

	localparam int unsigned VW = $clog2(VERTEX_COUNT);
	localparam int unsigned AW = $clog2(ADJ_DEPTH);

	state_t state_q, state_d;

	logic                     accept_c;
	logic                     slot_ok_c;
	cmd_t                     cmd_c;

	// direction of the running query
	logic signed [CoordW-1:0] dir_x_q, dir_y_q, dir_z_q;

	logic [VW-1:0]            next_q, cur_q, nb_q;
	logic [CountW-1:0]        cnt_q;
	logic [AW-1:0]            ptr_q;
	logic signed [ValueW-1:0] best_q;

	// visited map: epoch tag per vertex, cleared by a pass over all entries
	logic [EpochW-1:0]        vis_mem [VERTEX_COUNT];
	logic [EpochW-1:0]        vis_rd_q;
	logic [EpochW-1:0]        epoch_q;
	logic [VW-1:0]            clr_q;
	logic                     vis_re_c;
	logic                     vis_we_c;
	logic [VW-1:0]            vis_waddr_c;
	logic [EpochW-1:0]        vis_wdata_c;
	logic                     vis_hit_c;

	logic                     out_valid_q;
	logic [7:0]               support_vertex_q;
	logic signed [ValueW-1:0] support_value_q;

	// memory ports
	logic                     vrd_en_c;
	logic [VW-1:0]            vrd_addr_c;
	logic [PosW-1:0]          pos_rd;
	logic [ValW-1:0]          val_rd;
	logic                     ard_en_c;
	logic [NbW-1:0]           adj_rd;
	logic signed [ValueW-1:0] dot;

	logic [16:0]              start_red_c, nb_red_c, base_red_c, slot_red_c;
	logic [VW-1:0]            nb_c;

	assign cmd_c     = cmd_t'(command);
	assign accept_c  = in_valid && !in_stall;
	assign slot_ok_c = (11'(table_slot) < 11'(VERTEX_COUNT));

	assign start_red_c = reduce_mod(17'(start_vertex), 17'(VERTEX_COUNT));
	assign nb_red_c    = reduce_mod(17'(adj_rd), 17'(VERTEX_COUNT));
	assign base_red_c  = reduce_mod(17'(val_rd[OffW-1:0]), 17'(ADJ_DEPTH));
	assign slot_red_c  = reduce_mod(17'(table_slot), 17'(ADJ_DEPTH));
	assign nb_c        = nb_red_c[VW-1:0];

	assign vis_hit_c   = (vis_rd_q == epoch_q);

	csh_vtx_mem #(
		.VERTEX_COUNT(VERTEX_COUNT)
	) u_vtx_mem (
		.clk      (clk),
		.pos_we   (accept_c && cmd_c == CMD_WR_VERTEX && slot_ok_c),
		.val_we   (accept_c && cmd_c == CMD_WR_VALENCY && slot_ok_c),
		.wr_addr  (table_slot[VW-1:0]),
		.pos_wdata({coord_x, coord_y, coord_z}),
		.val_wdata({neighbor_count, neighbor_offset}),
		.rd_en    (vrd_en_c),
		.rd_addr  (vrd_addr_c),
		.pos_rdata(pos_rd),
		.val_rdata(val_rd)
	);

	csh_adj_mem #(
		.ADJ_DEPTH(ADJ_DEPTH)
	) u_adj_mem (
		.clk    (clk),
		.we     (accept_c && cmd_c == CMD_WR_ADJ),
		.wr_addr(slot_red_c[AW-1:0]),
		.wdata  (neighbor_vertex),
		.rd_en  (ard_en_c),
		.rd_addr(ptr_q),
		.rdata  (adj_rd)
	);

	csh_dot u_dot (
		.clk  (clk),
		.dir_x(dir_x_q),
		.dir_y(dir_y_q),
		.dir_z(dir_z_q),
		.pos  (pos_rd),
		.dot  (dot)
	);

	// visited map; a tag is written before any later lookup of the same entry
	// is issued, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (vis_we_c) begin
			vis_mem[vis_waddr_c] <= vis_wdata_c;
		end
		if (vis_re_c) begin
			vis_rd_q <= vis_mem[nb_c];
		end
	end

	// next state and memory read requests
	always_comb begin
		state_d     = state_q;
		vrd_en_c    = 1'b0;
		vrd_addr_c  = next_q;
		ard_en_c    = 1'b0;
		vis_re_c    = 1'b0;
		vis_we_c    = 1'b0;
		vis_waddr_c = nb_q;
		vis_wdata_c = epoch_q;
		case (state_q)
			ST_IDLE: begin
				if (accept_c && cmd_c == CMD_QUERY) begin
					state_d = ST_START_RD;
				end
			end
			ST_CLEAR: begin
				vis_we_c    = 1'b1;
				vis_waddr_c = clr_q;
				vis_wdata_c = '0;
				if (clr_q == VW'(VERTEX_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_START_RD: begin
				vrd_en_c = 1'b1;
				state_d  = ST_START_W1;
			end
			ST_START_W1: state_d = ST_START_W2;
			ST_START_W2: state_d = ST_START_SET;
			ST_START_SET: begin
				// valency of the start vertex
				vrd_en_c = 1'b1;
				state_d  = ST_VAL;
			end
			ST_VAL: state_d = ST_ADJ_RD;
			ST_ADJ_RD: begin
				if (cnt_q != '0) begin
					ard_en_c = 1'b1;
					state_d  = ST_ADJ;
				end else if (next_q != cur_q) begin
					vrd_en_c = 1'b1;
					state_d  = ST_VAL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_ADJ: begin
				// look up the neighbour's tag
				vis_re_c = 1'b1;
				state_d  = ST_VIS;
			end
			ST_VIS: begin
				if (vis_hit_c) begin
					state_d = ST_ADJ_RD;
				end else begin
					vis_we_c   = 1'b1;
					vrd_en_c   = 1'b1;
					vrd_addr_c = nb_q;
					state_d    = ST_NB_W1;
				end
			end
			ST_NB_W1:  state_d = ST_NB_W2;
			ST_NB_W2:  state_d = ST_NB_CMP;
			ST_NB_CMP: state_d = ST_ADJ_RD;
			ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					// tags exhausted: wipe the map before the next query
					state_d = (epoch_q == '1) ? ST_CLEAR : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// climb datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q    <= '0;
			cur_q     <= '0;
			next_q    <= '0;
			cnt_q     <= '0;
			ptr_q     <= '0;
			nb_q      <= '0;
			dir_x_q   <= '0;
			dir_y_q   <= '0;
			dir_z_q   <= '0;
			epoch_q   <= EpochW'(1);
			clr_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept_c && cmd_c == CMD_QUERY) begin
						dir_x_q   <= coord_x;
						dir_y_q   <= coord_y;
						dir_z_q   <= coord_z;
						next_q    <= start_red_c[VW-1:0];
					end
				end
				ST_CLEAR: begin
					if (clr_q == VW'(VERTEX_COUNT - 1)) begin
						clr_q <= '0;
					end else begin
						clr_q <= clr_q + VW'(1);
					end
				end
				ST_START_SET: begin
					best_q <= dot;
					cur_q  <= next_q;
				end
				ST_VAL: begin
					cnt_q <= val_rd[ValW-1:OffW];
					ptr_q <= base_red_c[AW-1:0];
				end
				ST_ADJ_RD: begin
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CountW'(1);
						if (ptr_q == AW'(ADJ_DEPTH - 1)) begin
							ptr_q <= '0;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end else if (next_q != cur_q) begin
						cur_q <= next_q;
					end
				end
				ST_ADJ: begin
					nb_q <= nb_c;
				end
				ST_NB_CMP: begin
					// strict improvement only
					if (dot > best_q) begin
						best_q <= dot;
						next_q <= nb_q;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || !out_stall) begin
						if (epoch_q == '1) begin
							epoch_q <= EpochW'(1);
						end else begin
							epoch_q <= epoch_q + EpochW'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			support_vertex_q <= 8'(cur_q);
			support_value_q  <= best_q;
		end
	end

	assign in_stall       = (state_q != ST_IDLE);
	assign out_valid      = out_valid_q;
	assign support_vertex = support_vertex_q;
	assign support_value  = support_value_q;

`ifndef SYNTHESIS
	// tag zero is kept for cleared entries
	a_epoch_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(epoch_q != '0))
		else $error("epoch tag reached zero");

	// a neighbour being evaluated has been marked
	a_nb_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NB_W1) |-> (vis_mem[nb_q] == epoch_q))
		else $error("evaluated neighbour not marked visited");

	// the running maximum never falls during a climb
	a_best_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NB_CMP) |=> (best_q >= $past(best_q)))
		else $error("running maximum decreased");

	// a result is only loaded from the end of a climb
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> ($past(state_q) == ST_DONE))
		else $error("result raised outside climb end");
`endif

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the convex support hill climber.
module tb_top;
	import csh_pkg::*;

	localparam int unsigned NV = 256;
	localparam int unsigned NA = 1024;
	localparam int unsigned IDLE_LIMIT = 20000;
	localparam int unsigned RANDOM_ITEMS = 900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] command = CMD_WR_VERTEX;
	logic [SlotW-1:0] table_slot = '0;
	logic [7:0] start_vertex = '0;
	logic signed [CoordW-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic [CountW-1:0] neighbor_count = '0;
	logic [OffW-1:0] neighbor_offset = '0;
	logic [NbW-1:0] neighbor_vertex = '0;
	logic out_valid;
	logic out_stall = 1'b1;
	logic [7:0] support_vertex;
	logic signed [ValueW-1:0] support_value;

	convex_support_hill_climb u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// transaction fields
	typedef struct {
		cmd_t cmd;
		logic [9:0] slot;
		logic [7:0] start;
		logic signed [17:0] x, y, z;
		logic [7:0] cnt;
		logic [9:0] off;
		logic [7:0] nb;
	} item_t;

	typedef struct {
		logic [7:0] vtx;
		logic signed [36:0] val;
	} support_t;

	// predictor's copy of the hull tables
	logic signed [17:0] hull_x[NV], hull_y[NV], hull_z[NV];
	logic [7:0] nb_count[NV];
	logic [9:0] nb_base[NV];
	logic [7:0] adj_list[NA];
	bit vtx_written[NV], val_written[NV], adj_written[NA];

	support_t pending_supports[$];
	int errors = 0;
	int queries_sent = 0, writes_sent = 0, supports_seen = 0;
	int idle_cycles = 0;
	bit long_hold = 1'b0;
	bit out_taken = 1'b0;
	int rx_wait = 0;

	function automatic logic signed [37:0] dot3(input item_t d, input int v);
		return 38'(hull_x[v]) * 38'(d.x) + 38'(hull_y[v]) * 38'(d.y)
			+ 38'(hull_z[v]) * 38'(d.z);
	endfunction

	// apply one transaction to the tables; queries yield the climbed support
	function automatic void apply_item(input item_t it);
		bit seen[NV];
		int nxt, cur, n;
		logic signed [37:0] best, v;
		support_t s;
		case (it.cmd)
			CMD_WR_VERTEX: if (it.slot < NV) begin
				hull_x[it.slot[7:0]] = it.x;
				hull_y[it.slot[7:0]] = it.y;
				hull_z[it.slot[7:0]] = it.z;
				vtx_written[it.slot[7:0]] = 1'b1;
			end
			CMD_WR_VALENCY: if (it.slot < NV) begin
				nb_count[it.slot[7:0]] = it.cnt;
				nb_base[it.slot[7:0]] = it.off;
				val_written[it.slot[7:0]] = 1'b1;
			end
			CMD_WR_ADJ: begin
				adj_list[it.slot] = it.nb;
				adj_written[it.slot] = 1'b1;
			end
			default: begin
				nxt = int'(it.start);
				best = dot3(it, nxt);
				do begin
					cur = nxt;
					for (int k = 0; k < nb_count[cur]; k++) begin
						n = adj_list[(nb_base[cur] + k) % NA];
						if (!seen[n]) begin
							seen[n] = 1'b1;
							v = dot3(it, n);
							if (v > best) begin
								best = v;
								nxt = n;
							end
						end
					end
				end while (nxt != cur);
				s.vtx = cur[7:0];
				s.val = best[36:0];
				pending_supports.push_back(s);
			end
		endcase
	endfunction

	// a query is legal only if every table entry the climb could touch is
	// written; check the reachable set conservatively
	function automatic bit query_safe(input int st);
		bit reach[NV];
		int work[$];
		int c, a;
		if (!vtx_written[st]) return 0;
		work.push_back(st);
		reach[st] = 1'b1;
		while (work.size() > 0) begin
			c = work.pop_front();
			if (!val_written[c]) return 0;
			for (int k = 0; k < nb_count[c]; k++) begin
				a = (nb_base[c] + k) % NA;
				if (!adj_written[a]) return 0;
				if (!vtx_written[adj_list[a]]) return 0;
				if (!reach[adj_list[a]]) begin
					reach[adj_list[a]] = 1'b1;
					work.push_back(adj_list[a]);
				end
			end
		end
		return 1;
	endfunction

	// drive one transaction at the falling edge and wait for acceptance;
	// valid stays up until the next call drops it or offers the next item
	task automatic send(input item_t it, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command <= it.cmd;
		table_slot <= it.slot;
		start_vertex <= it.start;
		coord_x <= it.x;
		coord_y <= it.y;
		coord_z <= it.z;
		neighbor_count <= it.cnt;
		neighbor_offset <= it.off;
		neighbor_vertex <= it.nb;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		apply_item(it);
		if (it.cmd == CMD_QUERY) queries_sent++;
		else writes_sent++;
		@(negedge clk);
	endtask

	function automatic item_t blank(input cmd_t c);
		item_t it;
		it.cmd = c;
		it.slot = '0; it.start = '0; it.x = '0; it.y = '0; it.z = '0;
		it.cnt = '0; it.off = '0; it.nb = '0;
		return it;
	endfunction

	function automatic item_t rand_item(input cmd_t c);
		item_t it;
		it.cmd = c;
		it.slot = 10'($urandom);
		it.start = 8'($urandom);
		it.x = 18'($urandom); it.y = 18'($urandom); it.z = 18'($urandom);
		it.cnt = 8'($urandom); it.off = 10'($urandom); it.nb = 8'($urandom);
		return it;
	endfunction

	// result side: a hold-off of random length after each taken result,
	// plus one long hold-off on request
	always @(negedge clk) begin
		if (!arst_n || long_hold) out_stall <= 1'b1;
		else if (out_taken) begin
			rx_wait = $urandom_range(0, 15);
			out_stall <= (rx_wait != 0);
		end else if (rx_wait > 0) begin
			rx_wait = rx_wait - 1;
			out_stall <= (rx_wait != 0);
		end
		else out_stall <= 1'b0;
	end

	// check each accepted support against the oldest prediction
	always @(posedge clk) begin
		out_taken = arst_n && out_valid && !out_stall;
		if (arst_n && out_valid && !out_stall) begin
			supports_seen++;
			if (pending_supports.size() == 0) begin
				errors++;
				$display("%0t: unexpected support v=%0d val=%0d", $time,
					support_vertex, support_value);
			end else begin
				support_t e;
				e = pending_supports.pop_front();
				if (e.vtx !== support_vertex) begin
					errors++;
					$display("%0t: support_vertex expected %0d got %0d", $time,
						e.vtx, support_vertex);
				end
				if (e.val !== support_value) begin
					errors++;
					$display("%0t: support_value expected %0d got %0d", $time,
						e.val, support_value);
				end
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog expired");
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// small random hull over a window of vertices: ring edges and chords
	task automatic build_hull(input int first, input int nverts, input int adj_base);
		item_t it;
		int a;
		for (int v = 0; v < nverts; v++) begin
			it = rand_item(CMD_WR_VERTEX);
			it.slot = 10'(first + v);
			if ($urandom_range(0, 4) == 0) begin
				it.x = $urandom_range(0, 1) ? 18'sh1ffff : -18'sh20000;
				it.y = $urandom_range(0, 1) ? 18'sh1ffff : -18'sh20000;
			end
			send(it, $urandom_range(0, 15));
		end
		a = adj_base;
		for (int v = 0; v < nverts; v++) begin
			int deg;
			deg = $urandom_range(0, 5);
			it = blank(CMD_WR_VALENCY);
			it.slot = 10'(first + v);
			it.cnt = 8'(deg);
			it.off = 10'(a);
			send(it, $urandom_range(0, 15));
			for (int k = 0; k < deg; k++) begin
				it = blank(CMD_WR_ADJ);
				it.slot = 10'((a + k) % NA);
				it.nb = 8'(first + ((k == 0) ? (v + 1) % nverts
					: $urandom_range(0, nverts - 1)));
				send(it, $urandom_range(0, 15));
			end
			a += deg;
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_supports.size() != 0) @(posedge clk);
		repeat (10) @(negedge clk);
	endtask

	item_t table_rows[$];
	item_t it;

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: extremes, out-of-range slots, adjacency wrap, zero direction
		it = blank(CMD_WR_VERTEX); it.slot = 0;
		it.x = 18'sh1ffff; it.y = -18'sh20000; it.z = 18'sh1ffff; table_rows.push_back(it);
		it = blank(CMD_WR_VERTEX); it.slot = 255;
		it.x = -18'sh20000; it.y = -18'sh20000; it.z = -18'sh20000; table_rows.push_back(it);
		it = blank(CMD_WR_VERTEX); it.slot = 1023; it.x = 5; table_rows.push_back(it);
		it = blank(CMD_WR_VALENCY); it.slot = 0; it.cnt = 1; it.off = 1023;
		table_rows.push_back(it);
		it = blank(CMD_WR_VALENCY); it.slot = 255; it.cnt = 2; it.off = 1023;
		table_rows.push_back(it);
		it = blank(CMD_WR_VALENCY); it.slot = 700; it.cnt = 255; table_rows.push_back(it);
		it = blank(CMD_WR_ADJ); it.slot = 1023; it.nb = 255; table_rows.push_back(it);
		it = blank(CMD_WR_ADJ); it.slot = 0; it.nb = 0; table_rows.push_back(it);
		// query from 0 toward (-1,-1,-1) direction extremes: climbs to 255
		it = blank(CMD_QUERY); it.start = 0;
		it.x = -18'sh20000; it.y = -18'sh20000; it.z = -18'sh20000; table_rows.push_back(it);
		it = blank(CMD_QUERY); it.start = 255;
		it.x = 18'sh1ffff; it.y = -18'sh20000; it.z = 18'sh1ffff; table_rows.push_back(it);
		it = blank(CMD_QUERY); it.start = 0; table_rows.push_back(it);
		foreach (table_rows[i]) send(table_rows[i], $urandom_range(0, 15));
		wait_drained();

		// random: build small hulls, then climb them many times
		while (writes_sent + queries_sent < RANDOM_ITEMS) begin
			int first, nv;
			nv = $urandom_range(4, 24);
			first = $urandom_range(0, NV - nv);
			build_hull(first, nv, $urandom_range(0, NA - 1));
			for (int q = 0; q < 40; q++) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: dropped out-of-range vertex or valency write
					it = rand_item($urandom_range(0, 1) ? CMD_WR_VERTEX : CMD_WR_VALENCY);
					it.slot = 10'($urandom_range(NV, 1023));
					send(it, $urandom_range(0, 15));
				end else begin
					it = rand_item(CMD_QUERY);
					if (!query_safe(it.start))
						it.start = 8'(first + $urandom_range(0, nv - 1));
					if (!query_safe(it.start)) continue;
					if ($urandom_range(0, 3) == 0) send(it, 0);
					else send(it, $urandom_range(0, 15));
				end
				if (queries_sent == 60 && !long_hold) begin
					// long receiver hold while queries keep coming
					fork
						begin
							long_hold = 1'b1;
							repeat (300) @(negedge clk);
							long_hold = 1'b0;
						end
					join_none
				end
			end
			// sender now and then pauses until all supports are in
			if ($urandom_range(0, 2) == 0) wait_drained();
		end

		wait_drained();
		repeat (200) @(posedge clk);
		$display("%0d table writes and %0d queries sent, %0d supports checked",
			writes_sent, queries_sent, supports_seen);
		if (errors == 0 && pending_supports.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/csh_pkg.sv
hdl/csh_vtx_mem.sv
hdl/csh_adj_mem.sv
hdl/csh_dot.sv
hdl/convex_support_hill_climb.sv
tb/tb_top.sv
